/* hdl/assert_macros.svh */
// Assertion macros for the RTL files; the decoder top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define PPBD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PPBD_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

/* hdl/ppbd_pkg.sv */
// Types, constants and codes of the pulse-pause bit decoder.
package ppbd_pkg;

   localparam int FRAME_BYTES_DEFAULT = 10;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int FIELD_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [FIELD_W-1:0] ONE_LOW_RESET       = 16'd850;
   localparam logic [FIELD_W-1:0] ONE_HIGH_RESET      = 16'd950;
   localparam logic [FIELD_W-1:0] ZERO_LOW_RESET      = 16'd450;
   localparam logic [FIELD_W-1:0] ZERO_HIGH_RESET     = 16'd550;
   localparam logic [FIELD_W-1:0] TIMEOUT_LIMIT_RESET = 16'd1356;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONE_LOW       = 3'd0,
      CSR_ONE_HIGH      = 3'd1,
      CSR_ZERO_LOW      = 3'd2,
      CSR_ZERO_HIGH     = 3'd3,
      CSR_TIMEOUT_LIMIT = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_INTERVAL = 1'b0,
      FUNC_ELAPSED  = 1'b1
   } func_type;

   typedef struct packed {
      logic               func;
      logic [FIELD_W-1:0] interval_cycles;
      logic [FIELD_W-1:0] elapsed_cycles;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic [3:0] byte_index;
      logic [6:0] total_bits;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_READ,
      ST_LOAD
   } state_type;

endpackage

/* hdl/ppbd_store.sv */
// Frame byte memory: one write port, one read port with registered data.
module ppbd_store #(
   parameter int DEPTH  = 10,
   parameter int ADDR_W = 4
) (
   input  logic                 clock,
   input  ppbd_pkg::mem_ctl_type mem_ctl,
   input  logic [ADDR_W-1:0]    rd_addr,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [7:0]           wr_data,
   output logic [7:0]           rd_data
);
   import ppbd_pkg::*;

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ppbd_ctrl.sv */
// Decoder control: window compares, bit packing sequencer and frame readout.
module ppbd_ctrl #(
   parameter int FRAME_BYTES = ppbd_pkg::FRAME_BYTES_DEFAULT,
   parameter int COUNT_WIDTH = ppbd_pkg::COUNT_WIDTH_DEFAULT,
   parameter int ADDR_W      = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [ppbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppbd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   input  ppbd_pkg::req_type                req_data,
   output logic                             req_stall,
   output ppbd_pkg::mem_ctl_type            mem_ctl,
   output logic [ADDR_W-1:0]                rd_addr,
   output logic [ADDR_W-1:0]                wr_addr,
   output logic [7:0]                       wr_data,
   input  logic [7:0]                       rd_data,
   input  logic                             rsp_free,
   output logic                             rsp_load,
   output ppbd_pkg::rsp_type                rsp_load_data
);
   import ppbd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam int CMP_W = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;
   localparam int TOT_W = (CNT_W + 3 > 7) ? CNT_W + 3 : 7;

   logic [FIELD_W-1:0] one_low_ff, one_high_ff, zero_low_ff, zero_high_ff, timeout_ff;

   state_type         state_ff, state_in;
   logic [2:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              bit_ff, bit_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic [6:0]        total_ff, total_in;

   logic [FIELD_W-1:0] interval, elapsed;
   logic               hit_one, hit_zero, is_interval, frame_empty, frame_full;
   logic               close_frame, append_bit;
   logic [CNT_W-1:0]   nbytes;
   logic [TOT_W-1:0]   total_wide;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         one_low_ff   <= ONE_LOW_RESET;
         one_high_ff  <= ONE_HIGH_RESET;
         zero_low_ff  <= ZERO_LOW_RESET;
         zero_high_ff <= ZERO_HIGH_RESET;
         timeout_ff   <= TIMEOUT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ONE_LOW:       one_low_ff   <= csr_write_data;
            CSR_ONE_HIGH:      one_high_ff  <= csr_write_data;
            CSR_ZERO_LOW:      zero_low_ff  <= csr_write_data;
            CSR_ZERO_HIGH:     zero_high_ff <= csr_write_data;
            CSR_TIMEOUT_LIMIT: timeout_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Item classification
   always_comb begin
      interval    = FIELD_W'(req_data.interval_cycles[CMP_W-1:0]);
      elapsed     = FIELD_W'(req_data.elapsed_cycles[CMP_W-1:0]);
      is_interval = (req_data.func == FUNC_INTERVAL);
      hit_one     = (interval > one_low_ff) && (interval < one_high_ff);
      hit_zero    = (interval > zero_low_ff) && (interval < zero_high_ff);
      frame_empty = (cnt_ff == '0) && (pos_ff == 3'd0);
      frame_full  = (cnt_ff == CNT_W'(FRAME_BYTES));
      append_bit  = is_interval && (hit_one || hit_zero) && !frame_full;
      close_frame = !frame_empty &&
                    (is_interval ? !(hit_one || hit_zero) : (elapsed > timeout_ff));
      nbytes      = cnt_ff + CNT_W'(pos_ff != 3'd0);
      total_wide  = (TOT_W'(cnt_ff) << 3) + TOT_W'(pos_ff);
   end

   // Next state and register updates
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      total_in = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (append_bit) begin
                  bit_in   = hit_one;
                  state_in = ST_MERGE;
               end else if (close_frame) begin
                  k_in     = '0;
                  last_in  = ADDR_W'(nbytes - CNT_W'(1));
                  total_in = total_wide[6:0];
                  pos_in   = 3'd0;
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_MERGE: begin
            pos_in = pos_ff + 3'd1;
            if (pos_ff == 3'd7) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               k_in     = k_ff + ADDR_W'(1);
               state_in = (k_ff == last_ff) ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      mem_ctl.rd_en = 1'b0;
      mem_ctl.wr_en = 1'b0;
      rd_addr       = cnt_ff[ADDR_W-1:0];
      wr_addr       = cnt_ff[ADDR_W-1:0];
      // The first bit of a byte starts it fresh: no clearing pass needed.
      wr_data       = ((pos_ff == 3'd0) ? 8'h00 : rd_data) | (8'(bit_ff) << pos_ff);
      rsp_load      = 1'b0;
      rsp_load_data.frame_byte = rd_data;
      rsp_load_data.byte_index = 4'(k_ff);
      rsp_load_data.total_bits = total_ff;
      rsp_load_data.last_byte  = (k_ff == last_ff);
      unique case (state_ff)
         ST_IDLE:  mem_ctl.rd_en = req_valid && append_bit;
         ST_MERGE: mem_ctl.wr_en = 1'b1;
         ST_READ: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = k_ff;
         end
         ST_LOAD:  rsp_load = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= 3'd0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff   <= bit_in;
      k_ff     <= k_in;
      last_ff  <= last_in;
      total_ff <= total_in;
   end

endmodule

/* hdl/pulse_pause_bit_decoder.sv */
// Pulse-pause bit decoder top level: frame memory, control and result register.
// Each transaction is an interval or an elapsed-time check; in-window intervals
// pack bits LSB first into a frame memory of FRAME_BYTES bytes, and a closing
// interval or timeout emits one result per started byte. A check item, a bit
// dropped on a full store or a closing item on an empty frame is taken at once;
// a bit item stalls the input for a read and a merged write-back on the frame
// memory. Closing a frame reads each byte from memory, then loads it into the
// result register, waiting while the result channel stalls; no input is taken
// meanwhile. The last result can wait in the result register while the next
// input is taken. No clearing pass follows reset: the first bit of each byte
// overwrites its entry.
`include "assert_macros.svh"

module pulse_pause_bit_decoder #(
   parameter int FRAME_BYTES = ppbd_pkg::FRAME_BYTES_DEFAULT,
   parameter int COUNT_WIDTH = ppbd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [ppbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ppbd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ppbd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppbd_pkg::rsp_type                rsp_data
);
   import ppbd_pkg::*;

   localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [7:0]        wr_data, rd_data;
   logic              rsp_free, rsp_load;
   rsp_type           rsp_load_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   ppbd_ctrl #(
      .FRAME_BYTES (FRAME_BYTES),
      .COUNT_WIDTH (COUNT_WIDTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data         (req_data),
      .req_stall        (req_stall),
      .mem_ctl          (mem_ctl),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_data          (rd_data),
      .rsp_free         (rsp_free),
      .rsp_load         (rsp_load),
      .rsp_load_data    (rsp_load_data)
   );

   ppbd_store #(
      .DEPTH  (FRAME_BYTES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Result register: free when empty or being taken this cycle
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_load_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PPBD_ASSERT(a_load_into_free, rsp_load |-> rsp_free, "result register overwritten")
   `PPBD_ASSERT(a_busy_on_load, rsp_load |-> req_stall, "input taken during frame readout")
   `PPBD_ASSERT(a_idle_after_last, rsp_load && rsp_load_data.last_byte |=> !req_stall,
      "decoder not idle after last byte")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the pulse-pause bit decoder: directed table, random frames.
module testbench;
   import ppbd_pkg::*;

   localparam int STORE_BYTES  = FRAME_BYTES_DEFAULT;
   localparam int IDLE_CYCLES  = 16;
   localparam int MAX_GAP      = 8;
   localparam int MAX_BURST    = 24;
   localparam int RUN_LIMIT_NS = 4_000_000;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stimulus_row_type;

   typedef enum {PACE_OPEN, PACE_LIGHT, PACE_HALF, PACE_HEAVY} pace_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;

   // decoder image: thresholds, frame bytes and fill position
   logic [15:0] one_lo, one_hi, zero_lo, zero_hi, time_limit;
   logic [7:0]  frame_image [STORE_BYTES];
   int          fill_bits;
   int          done_bytes;

   rsp_type fresh_bytes [$];
   rsp_type pending_bytes [$];

   bit driving;
   int burst_left;
   int items_sent, results_seen, mismatch_count;
   int frames_closed, full_frames, settings_applied;

   pulse_pause_bit_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d results still expected", pending_bytes.size());
      $display("pulse_pause_bit_decoder regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                   results_seen, name, got, want));
   endtask

   // ---- predictor ----

   function automatic void clear_frame();
      for (int k = 0; k < STORE_BYTES; k++) frame_image[k] = 8'h00;
      fill_bits  = 0;
      done_bytes = 0;
   endfunction

   function automatic void append_bit(input logic value);
      // drop bits once every byte of the store is complete
      if (done_bytes < STORE_BYTES) begin
         frame_image[done_bytes][fill_bits] = value;
         fill_bits++;
         if (fill_bits == 8) begin
            fill_bits = 0;
            done_bytes++;
         end
      end
   endfunction

   function automatic void close_frame();
      int      count;
      rsp_type part;
      count = done_bytes + ((fill_bits != 0) ? 1 : 0);
      if (count > STORE_BYTES) count = STORE_BYTES;
      for (int k = 0; k < count; k++) begin
         part.frame_byte = frame_image[k];
         part.byte_index = 4'(k);
         part.total_bits = 7'(done_bytes * 8 + fill_bits);
         part.last_byte  = (k == count - 1);
         fresh_bytes.push_back(part);
      end
      if (count != 0) frames_closed++;
      if (done_bytes == STORE_BYTES) full_frames++;
      clear_frame();
   endfunction

   function automatic void decode_pause_item(input req_type item);
      if (item.func == FUNC_INTERVAL) begin
         // the one window is tested first and wins on overlap
         if (item.interval_cycles > one_lo && item.interval_cycles < one_hi)
            append_bit(1'b1);
         else if (item.interval_cycles > zero_lo && item.interval_cycles < zero_hi)
            append_bit(1'b0);
         else
            close_frame();
      end else if (item.elapsed_cycles > time_limit && (done_bytes != 0 || fill_bits != 0)) begin
         close_frame();
      end
   endfunction

   // ---- stimulus helpers ----

   function automatic logic [15:0] pick_in_window(input logic [15:0] lo, input logic [15:0] hi);
      if (int'(hi) - int'(lo) > 1)
         return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_closing_interval();
      case ($urandom_range(0, 6))
         0: return one_lo;
         1: return one_hi;
         2: return zero_lo;
         3: return zero_hi;
         4: return 16'h0000;
         5: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic stimulus_row_type make_row(input func_type f, input logic [15:0] span,
                                                 input logic [15:0] elapsed, input bit typed,
                                                 input logic [7:0] value,
                                                 input logic [6:0] total);
      stimulus_row_type row;
      row.item.func            = f;
      row.item.interval_cycles = span;
      row.item.elapsed_cycles  = elapsed;
      row.typed                = typed;
      row.want                 = '{frame_byte: value, byte_index: 4'd0,
                                   total_bits: total, last_byte: 1'b1};
      return row;
   endfunction

   task automatic lower_valid();
      if (driving) begin
         req_valid <= 1'b0;
         driving = 1'b0;
      end
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      req_valid <= 1'b1;
      req_data  <= item;
      driving = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      decode_pause_item(item);
      items_sent++;
      if (typed) begin
         fresh_bytes.delete();
         pending_bytes.push_back(want);
      end else begin
         while (fresh_bytes.size() != 0) pending_bytes.push_back(fresh_bytes.pop_front());
      end
      if (burst_left == 0) begin
         lower_valid();
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         burst_left = $urandom_range(0, MAX_BURST);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      lower_valid();
      while (pending_bytes.size() != 0) @(posedge clock);
      // a bit or an empty close leaves no result to wait on
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         CSR_ONE_LOW:       one_lo     = value;
         CSR_ONE_HIGH:      one_hi     = value;
         CSR_ZERO_LOW:      zero_lo    = value;
         CSR_ZERO_HIGH:     zero_hi    = value;
         CSR_TIMEOUT_LIMIT: time_limit = value;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [15:0] ol, input logic [15:0] oh,
                                input logic [15:0] zl, input logic [15:0] zh,
                                input logic [15:0] tl);
      drain_results();
      // unused indexes must leave every threshold alone
      for (int k = int'(CSR_TIMEOUT_LIMIT) + 1; k < 2 ** CSR_INDEX_W; k++)
         write_register(CSR_INDEX_W'(k), 16'($urandom));
      write_register(CSR_ONE_LOW, ol);
      write_register(CSR_ONE_HIGH, oh);
      write_register(CSR_ZERO_LOW, zl);
      write_register(CSR_ZERO_HIGH, zh);
      write_register(CSR_TIMEOUT_LIMIT, tl);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic random_setting();
      logic [15:0] ol, zl;
      ol = 16'($urandom_range(0, 60000));
      zl = 16'($urandom_range(0, 60000));
      apply_setting(ol, 16'(ol + $urandom_range(2, 4000)),
                    zl, 16'(zl + $urandom_range(2, 4000)), 16'($urandom));
   endtask

   // well-formed frames with random content, some noise, then a closing transaction
   task automatic run_frames(input int budget);
      int      start, bits;
      req_type item;
      start = items_sent;
      while (items_sent - start < budget) begin
         bits = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 20);
         for (int k = 0; k < bits && items_sent - start < budget; k++) begin
            case ($urandom_range(0, 9))
               0: begin
                  item.func            = 1'($urandom_range(0, 1));
                  item.interval_cycles = 16'($urandom);
                  item.elapsed_cycles  = 16'($urandom);
               end
               1: begin
                  item.func            = FUNC_ELAPSED;
                  item.interval_cycles = 16'($urandom);
                  item.elapsed_cycles  = 16'($urandom_range(0, int'(time_limit)));
               end
               default: begin
                  item.func            = FUNC_INTERVAL;
                  item.interval_cycles = ($urandom_range(0, 1) == 1) ?
                                         pick_in_window(one_lo, one_hi) :
                                         pick_in_window(zero_lo, zero_hi);
                  item.elapsed_cycles  = 16'($urandom);
               end
            endcase
            send_item(item, 1'b0, '0);
         end
         if ($urandom_range(0, 4) < 3) begin
            item.func            = FUNC_INTERVAL;
            item.interval_cycles = pick_closing_interval();
            item.elapsed_cycles  = 16'($urandom);
         end else begin
            item.func            = FUNC_ELAPSED;
            item.interval_cycles = 16'($urandom);
            item.elapsed_cycles  = (time_limit != 16'hFFFF) ?
                                   16'($urandom_range(int'(time_limit) + 1, 65535)) :
                                   16'($urandom);
         end
         send_item(item, 1'b0, '0);
         // hold off now and then until the frame has fully drained
         if ($urandom_range(0, 7) == 0) drain_results();
      end
   endtask

   // ---- result channel ----

   initial begin : receiver_pace
      pace_type mode;
      int       span;
      rsp_stall <= 1'b0;
      forever begin
         mode = pace_type'($urandom_range(0, 3));
         span = $urandom_range(10, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               PACE_OPEN:  rsp_stall <= 1'b0;
               PACE_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               PACE_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
               PACE_HEAVY: rsp_stall <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected, frame_byte %02h",
                                      results_seen, rsp_data.frame_byte));
         end else begin
            want = pending_bytes.pop_front();
            compare_field("frame_byte", rsp_data.frame_byte, want.frame_byte);
            compare_field("byte_index", rsp_data.byte_index, want.byte_index);
            compare_field("total_bits", rsp_data.total_bits, want.total_bits);
            compare_field("last_byte", rsp_data.last_byte, want.last_byte);
         end
      end
   end

   // ---- main sequence ----

   initial begin : stimulus
      stimulus_row_type directed_rows [$];
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      one_lo     = ONE_LOW_RESET;
      one_hi     = ONE_HIGH_RESET;
      zero_lo    = ZERO_LOW_RESET;
      zero_hi    = ZERO_HIGH_RESET;
      time_limit = TIMEOUT_LIMIT_RESET;
      clear_frame();
      driving    = 1'b0;
      burst_left = $urandom_range(0, MAX_BURST);

      // reset thresholds: one in (850, 950), zero in (450, 550), timeout above 1356
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'hFFFF, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd0, 16'h0000, 1'b1, 8'h01, 7'd1));
      directed_rows.push_back(make_row(FUNC_ELAPSED, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd500, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd851, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd949, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_ELAPSED, 16'h0000, 16'd1356, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_ELAPSED, 16'h0000, 16'd1357, 1'b1, 8'h06, 7'd3));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd850, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd451, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd549, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd950, 16'h0000, 1'b1, 8'h00, 7'd2));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd500, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd500, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd500, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd900, 16'h0000, 1'b0, 8'h00, 7'd0));
      // nine bits spill into a partial second byte
      directed_rows.push_back(make_row(FUNC_INTERVAL, 16'd450, 16'h0000, 1'b0, 8'h00, 7'd0));
      directed_rows.push_back(make_row(FUNC_ELAPSED, 16'h0000, 16'h0000, 1'b0, 8'h00, 7'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
      run_frames(70);

      // overlapping windows: zero never matches
      apply_setting(16'd400, 16'd600, 16'd450, 16'd550, 16'd1000);
      run_frames(45);
      // widest windows, any nonzero elapsed time closes
      apply_setting(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      run_frames(45);
      // empty windows and no timeout: every interval closes an empty frame
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_frames(15);
      apply_setting(16'd100, 16'd200, 16'd200, 16'd300, 16'd300);
      run_frames(45);
      // single-value windows
      apply_setting(16'd1000, 16'd1002, 16'h0000, 16'd2, 16'hFFFE);
      run_frames(45);
      repeat (2) begin
         random_setting();
         run_frames(45);
      end

      drain_results();
      $display("covered %0d transactions in, %0d result bytes out, %0d register settings",
               items_sent, results_seen, settings_applied + 1);
      $display("%0d frames closed, %0d with a full store, %0d mismatches",
               frames_closed, full_frames, mismatch_count);
      if (mismatch_count == 0) begin
         $display("pulse_pause_bit_decoder regression: pass");
      end else begin
         $display("pulse_pause_bit_decoder regression: fail");
      end
      $finish;
   end

endmodule
